// File: sv/tllr_pkg.sv
// shared types and codes for the two-list lru reclaim core
`default_nettype none
package tllr_pkg;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_TOUCH = 2'd1,
        KIND_EVICT = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ZERO         = 3'd1,
        ST_DUP          = 3'd2,
        ST_FULL         = 3'd3,
        ST_NOT_INACTIVE = 3'd4,
        ST_VICTIM       = 3'd5,
        ST_NONE         = 3'd6,
        ST_NO_SLOT      = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_TCH_RD,
        S_TCH_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_EV_CHK,
        S_EV_OUT,
        S_RESP
    } t_state;

    localparam int unsigned FRAME_W = 64;
    localparam int unsigned CNT_W   = 7;

endpackage
`default_nettype wire

// File: sv/two_list_lru_reclaim_core.sv
// two-list lru reclaim core: top level with control sequencer
// input channel i_valid/o_ready carries one request beat: add, touch or evict.
// output channel o_valid/i_ready carries result beats; o_last marks the final one.
// both lists live in one ring memory: inactive entries from the head, active
// entries following them, so demoting the older half of the active list only
// moves the boundary.
// add: walks every listed entry, reading and then comparing each one.
// touch: walks the inactive list, reading and comparing each entry, then
// shifts the entries ahead of the hit up by one, reading and writing each.
// evict: reads each victim from the head, then sends it; an empty inactive
// list is refilled by demoting the older half of the active list.
// one request is worked at a time; a new request is taken once the previous
// one has produced its last beat into the output register.
// kind 3 is taken and produces no beat.
// a stalled receiver holds the output register and the sequencer waits on it.
// reset empties both lists at once; memory contents need no clearing pass.
`default_nettype none
module two_list_lru_reclaim_core #(
    parameter int unsigned LIST_DEPTH  = 256,
    parameter int unsigned MAX_VICTIMS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_frame,
    input  wire logic [6:0]  i_evict_count,
    input  wire logic [6:0]  i_free_slots,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [63:0]      o_victim_frame,
    output logic             o_last
);

    localparam int unsigned PW = $clog2(LIST_DEPTH) + 1;
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned CNTW = tllr_pkg::CNT_W;
    localparam logic [CNTW-1:0] MAXV = CNTW'(MAX_VICTIMS);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    tllr_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_icnt, n_icnt;
    logic [CW-1:0] r_acnt, n_acnt;
    logic [PW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_end, n_end;
    logic [63:0]   r_frame, n_frame;
    logic [CNTW-1:0] r_n, n_n;
    logic [CNTW-1:0] r_slots, n_slots;
    logic [CNTW-1:0] r_done, n_done;
    tllr_pkg::t_status r_st, n_st;

    logic          r_o_valid, n_o_valid;
    logic [2:0]    r_o_status, n_o_status;
    logic [63:0]   r_o_victim, n_o_victim;
    logic          r_o_last, n_o_last;

    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic          mem_re;
    logic [PW-1:0] mem_raddr;
    logic [63:0]   mem_rdata;

    logic          can_emit;
    logic          in_acc;
    logic [PW-1:0] bnd;
    logic [PW-1:0] tail;
    logic          ev_last;
    logic [CW-1:0] half;

    tllr_ram #(.AW(PW), .DW(64)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign can_emit = !r_o_valid || i_ready;
    assign o_ready  = (r_state == tllr_pkg::S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign bnd      = r_head + PW'(r_icnt);
    assign tail     = bnd + PW'(r_acnt);
    assign half     = r_acnt >> 1;
    assign ev_last  = ((r_done + 1'b1) == r_n) || ((r_icnt == CW'(1)) && (r_acnt < CW'(2)));

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_victim_frame = r_o_victim;
    assign o_last         = r_o_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tllr_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (tllr_pkg::t_kind'(i_kind))
                        tllr_pkg::KIND_ADD:
                            n_state = (i_frame == '0) ? tllr_pkg::S_RESP : tllr_pkg::S_ADD_RD;
                        tllr_pkg::KIND_TOUCH: n_state = tllr_pkg::S_TCH_RD;
                        tllr_pkg::KIND_EVICT: n_state = tllr_pkg::S_EV_CHK;
                        default:              n_state = tllr_pkg::S_IDLE;
                    endcase
                end
            end
            tllr_pkg::S_ADD_RD:
                n_state = (r_idx == r_end) ? tllr_pkg::S_RESP : tllr_pkg::S_ADD_CMP;
            tllr_pkg::S_ADD_CMP:
                n_state = (mem_rdata == r_frame) ? tllr_pkg::S_RESP : tllr_pkg::S_ADD_RD;
            tllr_pkg::S_TCH_RD:
                n_state = (r_idx == r_end) ? tllr_pkg::S_RESP : tllr_pkg::S_TCH_CMP;
            tllr_pkg::S_TCH_CMP:
                n_state = (mem_rdata == r_frame) ? tllr_pkg::S_SHF_RD : tllr_pkg::S_TCH_RD;
            tllr_pkg::S_SHF_RD:
                n_state = (r_idx == r_head) ? tllr_pkg::S_RESP : tllr_pkg::S_SHF_WR;
            tllr_pkg::S_SHF_WR: n_state = tllr_pkg::S_SHF_RD;
            tllr_pkg::S_EV_CHK: begin
                if (r_done == r_n) begin
                    n_state = tllr_pkg::S_RESP;
                end else if (r_icnt == '0) begin
                    if (r_acnt < CW'(2)) begin
                        n_state = (r_done == '0) ? tllr_pkg::S_RESP : tllr_pkg::S_IDLE;
                    end
                end else if (r_done >= r_slots) begin
                    n_state = tllr_pkg::S_RESP;
                end else begin
                    n_state = tllr_pkg::S_EV_OUT;
                end
            end
            tllr_pkg::S_EV_OUT: begin
                if (can_emit) begin
                    n_state = ev_last ? tllr_pkg::S_IDLE : tllr_pkg::S_EV_CHK;
                end
            end
            tllr_pkg::S_RESP: begin
                if (can_emit) begin
                    n_state = tllr_pkg::S_IDLE;
                end
            end
            default: n_state = tllr_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head     = r_head;
        n_icnt     = r_icnt;
        n_acnt     = r_acnt;
        n_idx      = r_idx;
        n_end      = r_end;
        n_frame    = r_frame;
        n_n        = r_n;
        n_slots    = r_slots;
        n_done     = r_done;
        n_st       = r_st;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_victim = r_o_victim;
        n_o_last   = r_o_last;
        mem_we     = 1'b0;
        mem_waddr  = tail;
        mem_wdata  = r_frame;
        mem_re     = 1'b0;
        mem_raddr  = r_idx;
        unique case (r_state)
            tllr_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_frame = i_frame;
                    n_n     = (i_evict_count > MAXV) ? MAXV : i_evict_count;
                    n_slots = i_free_slots;
                    n_done  = '0;
                    n_idx   = r_head;
                    n_end   = (tllr_pkg::t_kind'(i_kind) == tllr_pkg::KIND_ADD) ? tail : bnd;
                    n_st    = tllr_pkg::ST_ZERO;
                end
            end
            tllr_pkg::S_ADD_RD: begin
                if (r_idx == r_end) begin
                    if (r_acnt >= DEPTH_C) begin
                        n_st = tllr_pkg::ST_FULL;
                    end else begin
                        mem_we = 1'b1;
                        n_acnt = r_acnt + 1'b1;
                        n_st   = tllr_pkg::ST_OK;
                    end
                end else begin
                    mem_re = 1'b1;
                end
            end
            tllr_pkg::S_ADD_CMP: begin
                if (mem_rdata == r_frame) begin
                    n_st = tllr_pkg::ST_DUP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tllr_pkg::S_TCH_RD: begin
                if (r_idx == r_end) begin
                    n_st = tllr_pkg::ST_NOT_INACTIVE;
                end else begin
                    mem_re = 1'b1;
                end
            end
            tllr_pkg::S_TCH_CMP: begin
                if (mem_rdata != r_frame) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tllr_pkg::S_SHF_RD: begin
                if (r_idx == r_head) begin
                    n_head = r_head + 1'b1;
                    n_icnt = r_icnt - 1'b1;
                    if (r_acnt < DEPTH_C) begin
                        mem_we = 1'b1;
                        n_acnt = r_acnt + 1'b1;
                        n_st   = tllr_pkg::ST_OK;
                    end else begin
                        n_st = tllr_pkg::ST_FULL;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - 1'b1;
                end
            end
            tllr_pkg::S_SHF_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = r_idx - 1'b1;
            end
            tllr_pkg::S_EV_CHK: begin
                if (r_done == r_n) begin
                    n_st = tllr_pkg::ST_NONE;
                end else if (r_icnt == '0) begin
                    if (r_acnt < CW'(2)) begin
                        n_st = tllr_pkg::ST_NONE;
                    end else begin
                        n_icnt = half;
                        n_acnt = r_acnt - half;
                    end
                end else if (r_done >= r_slots) begin
                    n_st = tllr_pkg::ST_NO_SLOT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_head;
                end
            end
            tllr_pkg::S_EV_OUT: begin
                if (can_emit) begin
                    n_o_valid  = 1'b1;
                    n_o_status = tllr_pkg::ST_VICTIM;
                    n_o_victim = mem_rdata;
                    n_o_last   = ev_last;
                    n_head     = r_head + 1'b1;
                    n_icnt     = r_icnt - 1'b1;
                    n_done     = r_done + 1'b1;
                end
            end
            tllr_pkg::S_RESP: begin
                if (can_emit) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_st;
                    n_o_victim = '0;
                    n_o_last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tllr_pkg::S_IDLE;
            r_head    <= '0;
            r_icnt    <= '0;
            r_acnt    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_icnt    <= n_icnt;
            r_acnt    <= n_acnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_end      <= n_end;
        r_frame    <= n_frame;
        r_n        <= n_n;
        r_slots    <= n_slots;
        r_done     <= n_done;
        r_st       <= n_st;
        r_o_status <= n_o_status;
        r_o_victim <= n_o_victim;
        r_o_last   <= n_o_last;
    end

    a_acnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acnt <= DEPTH_C)
        else $error("active count overflow");

    a_icnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_icnt <= DEPTH_C)
        else $error("inactive count overflow");

    a_victim_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tllr_pkg::S_EV_OUT) |-> (r_icnt != '0))
        else $error("victim taken from empty inactive list");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tllr_pkg::S_IDLE) |-> !o_ready)
        else $error("request taken while busy");

endmodule
`default_nettype wire

// File: sv/tllr_ram.sv
// single write port, single registered read port frame ring memory
`default_nettype none
module tllr_ram #(
    parameter int unsigned AW = 9,
    parameter int unsigned DW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: tb/tb_two_list_lru_reclaim_core.sv
// testbench for the two-list lru reclaim core: directed and random requests checked beat by beat
`default_nettype none
module tb_two_list_lru_reclaim_core;

    localparam int unsigned DEPTH   = 256;
    localparam int unsigned VMAX    = 64;
    localparam int unsigned DRAIN_CYCLES = 1200;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] victim;
        logic        last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = tllr_pkg::KIND_NONE;
    logic [63:0] i_frame = '0;
    logic [6:0]  i_evict_count = '0;
    logic [6:0]  i_free_slots = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [63:0] o_victim_frame;
    logic        o_last;

    logic [63:0] act_frames [DEPTH];
    logic [63:0] inact_frames [DEPTH];
    int unsigned act_cnt;
    int unsigned inact_cnt;
    t_beat       beats_due [$];
    int unsigned errors;
    int unsigned idle_pct;
    int unsigned stall_pct;
    logic [63:0] frame_pool [40];

    two_list_lru_reclaim_core dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #60000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_beat due;
        if (i_rst_n && o_valid && i_ready) begin
            if (beats_due.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: status %0d victim %h last %0d",
                         $time, o_status, o_victim_frame, o_last);
            end else begin
                due = beats_due.pop_front();
                if (o_status !== due.status) begin
                    errors++;
                    $display("%0t status: expected %0d actual %0d", $time, due.status,
                             o_status);
                end
                if (o_victim_frame !== due.victim) begin
                    errors++;
                    $display("%0t victim: expected %h actual %h", $time, due.victim,
                             o_victim_frame);
                end
                if (o_last !== due.last) begin
                    errors++;
                    $display("%0t last: expected %0d actual %0d", $time, due.last, o_last);
                end
            end
        end
    end

    function automatic bit find_frame(bit in_act, logic [63:0] f, output int unsigned pos);
        int unsigned n;
        n = in_act ? act_cnt : inact_cnt;
        for (int unsigned i = 0; i < n; i++) begin
            if ((in_act ? act_frames[i] : inact_frames[i]) == f) begin
                pos = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void push_beat(tllr_pkg::t_status st, logic [63:0] v, bit lst);
        t_beat b;
        b.status = st;
        b.victim = v;
        b.last = lst;
        beats_due.push_back(b);
    endfunction

    function automatic void remove_inactive(int unsigned pos);
        for (int unsigned i = pos; i + 1 < inact_cnt; i++) inact_frames[i] = inact_frames[i + 1];
        inact_cnt--;
    endfunction

    function automatic void predict_reclaim(logic [1:0] kind, logic [63:0] f,
                                            logic [6:0] want, logic [6:0] slots);
        int unsigned pos;
        int unsigned n;
        int unsigned done;
        int unsigned move;
        bit short_slot;
        case (kind)
            tllr_pkg::KIND_ADD: begin
                if (f == 0) push_beat(tllr_pkg::ST_ZERO, '0, 1'b1);
                else if (find_frame(1'b1, f, pos) || find_frame(1'b0, f, pos))
                    push_beat(tllr_pkg::ST_DUP, '0, 1'b1);
                else if (act_cnt >= DEPTH) push_beat(tllr_pkg::ST_FULL, '0, 1'b1);
                else begin
                    act_frames[act_cnt++] = f;
                    push_beat(tllr_pkg::ST_OK, '0, 1'b1);
                end
            end
            tllr_pkg::KIND_TOUCH: begin
                if (!find_frame(1'b0, f, pos)) push_beat(tllr_pkg::ST_NOT_INACTIVE, '0, 1'b1);
                else begin
                    remove_inactive(pos);
                    if (act_cnt < DEPTH) begin
                        act_frames[act_cnt++] = f;
                        push_beat(tllr_pkg::ST_OK, '0, 1'b1);
                    end else push_beat(tllr_pkg::ST_FULL, '0, 1'b1);
                end
            end
            tllr_pkg::KIND_EVICT: begin
                n = (want > VMAX) ? VMAX : want;
                done = 0;
                short_slot = 1'b0;
                while (done < n) begin
                    if (inact_cnt == 0) begin
                        move = act_cnt / 2;
                        if (move == 0) break;
                        for (int unsigned i = 0; i < move; i++) inact_frames[i] = act_frames[i];
                        inact_cnt = move;
                        for (int unsigned i = 0; i + move < act_cnt; i++)
                            act_frames[i] = act_frames[i + move];
                        act_cnt -= move;
                    end else if (done >= slots) begin
                        short_slot = 1'b1;
                        break;
                    end else begin
                        push_beat(tllr_pkg::ST_VICTIM, inact_frames[0], 1'b0);
                        remove_inactive(0);
                        done++;
                    end
                end
                // last flag is settled once the run is known
                if (short_slot) push_beat(tllr_pkg::ST_NO_SLOT, '0, 1'b1);
                else if (done == 0) push_beat(tllr_pkg::ST_NONE, '0, 1'b1);
                else beats_due[beats_due.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic send_beat(logic [1:0] kind, logic [63:0] f, logic [6:0] want,
                             logic [6:0] slots);
        int unsigned gap;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_frame <= f;
        i_evict_count <= want;
        i_free_slots <= slots;
        do @(posedge i_clk); while (!o_ready);
        predict_reclaim(kind, f, want, slots);
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        int unsigned spare;
        i_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        spare = DRAIN_CYCLES;
        repeat (spare) @(posedge i_clk);
    endtask

    task automatic test_add_cases();
        send_beat(tllr_pkg::KIND_ADD, '0, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 7'd127);
        send_beat(tllr_pkg::KIND_ADD, 64'd1, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_ADD, 64'd1, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_NONE, 64'd5, 7'd3, 7'd3);
    endtask

    task automatic test_touch_cases();
        send_beat(tllr_pkg::KIND_TOUCH, '0, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_TOUCH, 64'd1, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_EVICT, '0, 7'd1, 7'd0);
        send_beat(tllr_pkg::KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_TOUCH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_TOUCH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 7'd0);
    endtask

    task automatic test_evict_cases();
        send_beat(tllr_pkg::KIND_EVICT, '0, 7'd0, 7'd64);
        send_beat(tllr_pkg::KIND_EVICT, '0, 7'd127, 7'd127);
        send_beat(tllr_pkg::KIND_EVICT, '0, 7'd5, 7'd5);
        send_beat(tllr_pkg::KIND_ADD, 64'd2, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_ADD, 64'd3, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_EVICT, '0, 7'd3, 7'd1);
        wait_drained();
    endtask

    task automatic test_full_lists();
        send_beat(tllr_pkg::KIND_ADD, 64'd10, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_EVICT, '0, 7'd1, 7'd0);
        for (int unsigned i = 0; i < DEPTH; i++)
            send_beat(tllr_pkg::KIND_ADD, 64'd1000 + i, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_TOUCH, 64'd10, 7'd0, 7'd0);
        send_beat(tllr_pkg::KIND_ADD, 64'd10, 7'd0, 7'd0);
        for (int unsigned i = 0; i < 9; i++) send_beat(tllr_pkg::KIND_EVICT, '0, 7'd64, 7'd64);
        wait_drained();
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned r;
        logic [63:0] f;
        logic [1:0] kind;
        logic [6:0] want;
        logic [6:0] slots;
        for (int unsigned i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            kind = (r < 45) ? tllr_pkg::KIND_ADD : (r < 70) ? tllr_pkg::KIND_TOUCH :
                   (r < 96) ? tllr_pkg::KIND_EVICT : tllr_pkg::KIND_NONE;
            r = $urandom_range(0, 99);
            f = (r < 3) ? 64'd0 : (r < 10) ? {$urandom, $urandom} :
                frame_pool[$urandom_range(0, 39)];
            want = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
                   7'($urandom_range(0, 8));
            slots = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
                    7'($urandom_range(0, 8));
            send_beat(kind, f, want, slots);
        end
    endtask

    initial begin
        act_cnt = 0;
        inact_cnt = 0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 40; i++) frame_pool[i] = {$urandom, $urandom} | 64'd1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_add_cases();
        test_touch_cases();
        test_evict_cases();
        idle_pct = 19;
        stall_pct = 19;
        test_full_lists();
        idle_pct = 0;
        stall_pct = 0;
        test_random_traffic(6);
        idle_pct = 72;
        test_random_traffic(6);
        wait_drained();
        idle_pct = 0;
        stall_pct = 72;
        test_random_traffic(6);
        idle_pct = 19;
        stall_pct = 19;
        test_random_traffic(6);
        wait_drained();
        if (errors == 0 && beats_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
